FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk once reset has been released.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of i_clk, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Constants and types shared by the shuffled Lehmer generator modules.
// ----------------------------------------------------------------------------
package slrg_pkg;

    // Minimal-standard Lehmer generator constants.
    localparam logic [14:0] LEHMER_MUL   = 15'd16807;
    localparam logic [30:0] LEHMER_MOD   = 31'h7FFF_FFFF;
    localparam int          WARMUP_EXTRA = 8;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_RD,
        ST_DRAW
    } t_state;

endpackage

FILE: rtl/core/slrg_ram.sv
// ----------------------------------------------------------------------------
// slrg_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module slrg_ram #(
    parameter  int WIDTH  = 31,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/slrg_lehmer.sv
// ----------------------------------------------------------------------------
// slrg_lehmer
// One Lehmer step, x * 16807 mod (2^31 - 1): registered multiply, then a
// Mersenne-modulus fold and one conditional subtract.
// ----------------------------------------------------------------------------
module slrg_lehmer (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic [30:0] i_x,
    output logic [30:0] o_next
);

    import slrg_pkg::*;

    logic [45:0] r_prod;
    logic [31:0] w_sum;

    // The product holds until the next start, so the result stays valid.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= 46'(i_x) * 46'(LEHMER_MUL);
        end
    end

    // Since 2^31 is 1 modulo the modulus, the high part folds onto the low part.
    always_comb begin
        w_sum = {1'b0, r_prod[30:0]} + 32'(r_prod[45:31]);
        if (w_sum >= 32'(LEHMER_MOD)) begin
            o_next = 31'(w_sum - 32'(LEHMER_MOD));
        end else begin
            o_next = w_sum[30:0];
        end
    end

endmodule

FILE: rtl/core/shuffled_lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// Minimal-standard Lehmer generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Word
//  input    in         i_valid / o_ready   i_action, i_seed_value
//  output   out        o_valid / i_ready   o_random_value
//
//  A draw reads the table entry while the Lehmer multiply runs, then, once
//  the output is free, writes back the new generator value in DRAW.
//  A reseed, or the first draw after reset, first runs the warm-up: each
//  warm-up step is a registered multiply and a modulus fold.
//  Reset clears the generator and the previous output; the table is written
//  by seeding before any read. A stalled output holds the next word in DRAW.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shuffled_lehmer_random_generator #(
    parameter int TABLE_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [30:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_random_value
);

    import slrg_pkg::*;

    localparam int          ADDR_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int          CNT_TOP = TABLE_SIZE + WARMUP_EXTRA - 1;
    localparam int          CNT_W   = $clog2(CNT_TOP + 1);
    localparam int unsigned BUCKET  = 1 + (32'(LEHMER_MOD) - 1) / TABLE_SIZE;

    t_state              r_state, n_state;
    logic [30:0]         r_gen, n_gen;
    logic [30:0]         r_prev, n_prev;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_out_valid;
    logic [30:0]         r_out_data;

    logic                w_mul_start;
    logic [30:0]         w_next;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic                w_ram_re;
    logic [30:0]         w_ram_rdata;
    logic [ADDR_W-1:0]   w_idx;
    logic                w_out_load;
    logic                w_out_free;

    // A seed of zero, or one equal to the modulus, would lock the generator at 0.
    function automatic logic [30:0] fix_seed(input logic [30:0] s);
        if (s == 31'd0 || s == LEHMER_MOD) begin
            return 31'd1;
        end
        return s;
    endfunction

    // Shared Lehmer step unit; its operand is always the current generator value.
    slrg_lehmer u_lehmer (
        .i_clk   (i_clk),
        .i_start (w_mul_start),
        .i_x     (r_gen),
        .o_next  (w_next)
    );

    // Shuffle table.
    slrg_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_next),
        .i_re    (w_ram_re),
        .i_raddr (w_idx),
        .o_rdata (w_ram_rdata)
    );

    // Table index: how many bucket boundaries the previous output has passed.
    // The count tops out at TABLE_SIZE - 1, which gives the clamp for free.
    always_comb begin
        w_idx = '0;
        for (int j = 1; j < TABLE_SIZE; j++) begin
            if (32'(r_prev) >= 32'(j * BUCKET)) begin
                w_idx = ADDR_W'(j);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    // Sequencer: next state, register updates and memory controls.
    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_prev      = r_prev;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        w_mul_start = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_re    = 1'b0;
        w_out_load  = 1'b0;
        o_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action || r_prev == 31'd0) begin
                        n_gen   = fix_seed(i_action ? i_seed_value : r_gen);
                        n_cnt   = CNT_W'(CNT_TOP);
                        n_state = ST_SEED_MUL;
                    end else begin
                        w_mul_start = 1'b1;
                        w_ram_re    = 1'b1;
                        n_idx       = w_idx;
                        n_state     = ST_DRAW;
                    end
                end
            end
            ST_SEED_MUL: begin
                w_mul_start = 1'b1;
                n_state     = ST_SEED_RED;
            end
            ST_SEED_RED: begin
                n_gen = w_next;
                // The last TABLE_SIZE warm-up values fill the table from the top down.
                if (r_cnt < CNT_W'(TABLE_SIZE)) begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_cnt[ADDR_W-1:0];
                end
                if (r_cnt == '0) begin
                    n_prev  = w_next;
                    n_state = ST_DRAW_RD;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = ST_SEED_MUL;
                end
            end
            ST_DRAW_RD: begin
                w_mul_start = 1'b1;
                w_ram_re    = 1'b1;
                n_idx       = w_idx;
                n_state     = ST_DRAW;
            end
            ST_DRAW: begin
                // Swap the picked entry for the new generator value.
                if (w_out_free) begin
                    w_ram_we   = 1'b1;
                    n_gen      = w_next;
                    n_prev     = w_ram_rdata;
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gen   <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_gen   <= n_gen;
            r_prev  <= n_prev;
        end
    end

    // Warm-up counter and held table index.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_ram_rdata;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_data;

    // A delivered word is never zero once the table has been seeded.
    `ASSERT_CLKD(a_out_nonzero, !o_valid || o_random_value != 31'd0, "zero output word")
    // The generator is seeded before any draw completes.
    `ASSERT_CLKD(a_gen_seeded, (r_state == ST_DRAW) |-> (r_gen != 31'd0), "unseeded draw")
    // The post-seed read follows only the final warm-up step.
    `ASSERT_CLKD(a_seed_done, (r_state == ST_DRAW_RD) |-> ($past(r_state) == ST_SEED_RED && $past(r_cnt) == '0), "early draw after seed")

endmodule
